### design/rcam_pkg.sv
// ----------------------------------------------------------------------------
// rcam_pkg
// Shared widths, register indexes, codes and the per-core store entry.
// ----------------------------------------------------------------------------
package rcam_pkg;

    localparam int NUM_CORES_DEF = 16;

    localparam int DATA_W     = 64;
    localparam int BASE_W     = 32;
    localparam int DZ_W       = 10;
    localparam int CNT_W      = 16;
    localparam int CORE_IN_W  = 4;
    localparam int CORE_EXT_W = 6;   // holds any core count up to 63
    localparam int CFG_IDX_W  = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASELINE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STORM_THR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_AVG = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_SPR = 3'd5;

    // register reset values
    localparam logic [BASE_W-1:0] BASELINE_RST  = 32'd15014;
    localparam logic [DZ_W-1:0]   DEAD_ZONE_RST = 10'd0;
    localparam logic [CNT_W-1:0]  BATCH_RST     = 16'd50;
    localparam logic [CNT_W-1:0]  STORM_THR_RST = 16'd3;
    localparam logic [DATA_W-1:0] DELTA_AVG_RST = 64'd25000;
    localparam logic [DATA_W-1:0] DELTA_SPR_RST = 64'd20000;

    // transaction codes
    localparam logic OP_RECORD    = 1'b0;
    localparam logic OP_EVALUATE  = 1'b1;
    localparam logic KIND_CORE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0]  clean;
        logic [DATA_W-1:0] min_delta;
        logic              off;
    } t_entry;

endpackage

### design/rcam_alu.sv
// ----------------------------------------------------------------------------
// rcam_alu
// Shared 64-bit add/subtract unit; carry out doubles as the unsigned compare.
// ----------------------------------------------------------------------------
module rcam_alu (
    input  logic [rcam_pkg::DATA_W-1:0] i_a,
    input  logic [rcam_pkg::DATA_W-1:0] i_b,
    input  logic                        i_sub,
    output logic [rcam_pkg::DATA_W-1:0] o_sum,
    output logic                        o_carry
);

    logic [rcam_pkg::DATA_W-1:0] b_op;
    logic [rcam_pkg::DATA_W:0]   full;

    assign b_op = i_sub ? ~i_b : i_b;
    // subtract: carry low means a < b
    assign full = {1'b0, i_a} + {1'b0, b_op} + {{rcam_pkg::DATA_W{1'b0}}, i_sub};
    assign o_sum   = full[rcam_pkg::DATA_W-1:0];
    assign o_carry = full[rcam_pkg::DATA_W];

endmodule

### design/rcam_store.sv
// ----------------------------------------------------------------------------
// rcam_store
// Per-core statistics memory, one write and one registered read per cycle.
// Valid bits make unwritten or cleared entries read as zero.
// ----------------------------------------------------------------------------
module rcam_store #(
    parameter  int NUM_CORES = rcam_pkg::NUM_CORES_DEF,
    localparam int CORE_W    = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rd_en,
    input  logic [CORE_W-1:0]   i_rd_addr,
    output rcam_pkg::t_entry    o_rd_data,
    input  logic                i_wr_en,
    input  logic [CORE_W-1:0]   i_wr_addr,
    input  rcam_pkg::t_entry    i_wr_data,
    input  logic                i_clr
);

    rcam_pkg::t_entry    r_mem [NUM_CORES];
    logic [NUM_CORES-1:0] r_vld;
    rcam_pkg::t_entry    r_rd_data;
    logic                r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_clr) begin
                r_vld <= '0;
            end else if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

### design/retired_count_anomaly_monitor_top.sv
// ----------------------------------------------------------------------------
// retired_count_anomaly_monitor_top
// Scores retired-instruction samples per core and reports a batch verdict.
//
//   channel   direction  handshake                  payload
//   in        input      i_in_valid / o_in_stall    operation, core, counts
//   out       output     o_out_valid / i_out_stall  report or summary fields
//   cfg       input      i_cfg_we (write only)      i_cfg_index, i_cfg_data
//
// Record: diff, score and update states with the counter enabled, diff only
// with it disabled, none for a core out of range. Evaluate: capture, storm and
// lowest states per core, then the summary states. All arithmetic runs through
// one 64-bit add/subtract unit, one operation per cycle.
// Reset: synchronous, active low; the store reads as zero right after reset
// (per-entry valid bits), so there is no clearing pass.
// Stalls: a stalled report holds the scan; input is stalled whenever busy.
// ----------------------------------------------------------------------------
module retired_count_anomaly_monitor_top #(
    parameter int NUM_CORES = rcam_pkg::NUM_CORES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input transactions
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_operation,
    input  logic [rcam_pkg::CORE_IN_W-1:0]    i_core_index,
    input  logic                              i_counter_enabled,
    input  logic [rcam_pkg::DATA_W-1:0]       i_count_before,
    input  logic [rcam_pkg::DATA_W-1:0]       i_count_after,
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [rcam_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rcam_pkg::DATA_W-1:0]       i_cfg_data,
    // output transactions
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_report_kind,
    output logic [rcam_pkg::CORE_IN_W-1:0]    o_report_core,
    output logic [rcam_pkg::CNT_W-1:0]        o_clean_samples,
    output logic [rcam_pkg::DATA_W-1:0]       o_least_delta,
    output logic                              o_counter_was_off,
    output logic [rcam_pkg::CNT_W-1:0]        o_captured_count,
    output logic                              o_core_storming,
    output logic [rcam_pkg::DATA_W-1:0]       o_lowest_delta,
    output logic                              o_delta_in_window,
    output logic                              o_any_storming,
    output logic                              o_last
);

    localparam int CORE_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int DW     = rcam_pkg::DATA_W;
    localparam int CW     = rcam_pkg::CNT_W;

    // sequencer: R_* record, E_* per-core scan, S_* summary
    typedef enum logic [10:0] {
        ST_IDLE     = 11'b000_0000_0001,
        ST_R_DIFF   = 11'b000_0000_0010,
        ST_R_SCORE  = 11'b000_0000_0100,
        ST_R_UPD    = 11'b000_0000_1000,
        ST_E_CAP    = 11'b000_0001_0000,
        ST_E_STM    = 11'b000_0010_0000,
        ST_E_LOW    = 11'b000_0100_0000,
        ST_S_HI     = 11'b000_1000_0000,
        ST_S_CMPHI  = 11'b001_0000_0000,
        ST_S_LO     = 11'b010_0000_0000,
        ST_S_CMPLO  = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [rcam_pkg::BASE_W-1:0] r_baseline;
    logic [rcam_pkg::DZ_W-1:0]   r_dead_zone;
    logic [CW-1:0]               r_batch;
    logic [CW-1:0]               r_storm_thr;
    logic [DW-1:0]               r_delta_avg;
    logic [DW-1:0]               r_delta_spr;

    // working registers
    logic              r_enabled;
    logic [CORE_W-1:0] r_core;
    logic [DW-1:0]     r_before;
    logic [DW-1:0]     r_after;
    logic [DW-1:0]     r_acc;
    logic [CORE_W-1:0] r_idx;
    logic [CW-1:0]     r_cap;
    logic [DW-1:0]     r_lowest;
    logic              r_storm;
    logic              r_lt_hi;

    // output registers
    logic          r_o_valid;
    logic          r_o_kind;
    logic [3:0]    r_o_core;
    logic [CW-1:0] r_o_clean;
    logic [DW-1:0] r_o_least;
    logic          r_o_off;
    logic [CW-1:0] r_o_cap;
    logic          r_o_storming;
    logic [DW-1:0] r_o_lowest;
    logic          r_o_in_win;
    logic          r_o_any;
    logic          r_o_last;

    logic                              in_acc;
    logic                              out_free;
    logic [rcam_pkg::CORE_EXT_W-1:0]   core_ext;
    logic                              core_ok;
    logic                              idx_last;
    rcam_pkg::t_entry                  entry;
    rcam_pkg::t_entry                  wr_data;
    logic                              rd_en;
    logic [CORE_W-1:0]                 rd_addr;
    logic                              wr_en;
    logic                              clr;
    logic [DW-1:0]                     alu_a, alu_b, alu_sum;
    logic                              alu_sub, alu_carry, alu_borrow;
    logic signed [31:0]                low_s, dz_s;
    logic                              in_zone;
    logic [DW-1:0]                     score;
    logic                              st_now;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign out_free   = !r_o_valid || !i_out_stall;
    assign core_ext   = rcam_pkg::CORE_EXT_W'(i_core_index);
    assign core_ok    = core_ext < rcam_pkg::CORE_EXT_W'(NUM_CORES);
    assign idx_last   = (r_idx == CORE_W'(NUM_CORES - 1));
    assign alu_borrow = !alu_carry;

    // dead zone on the signed low word of the score
    assign low_s   = signed'(r_acc[31:0]);
    assign dz_s    = signed'(32'(r_dead_zone));
    assign in_zone = (low_s < dz_s) && (low_s > -dz_s);
    assign score   = in_zone ? '0 : r_acc;

    // storming test for the core under scan (cap - threshold in the unit)
    assign st_now = (entry.min_delta != '0) && !alu_borrow;

    rcam_alu u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_sub   (alu_sub),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    rcam_store #(.NUM_CORES(NUM_CORES)) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (entry),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_core),
        .i_wr_data (wr_data),
        .i_clr     (clr)
    );

    // shared unit operand select
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        unique case (r_state)
            ST_R_DIFF: begin
                alu_a = r_after;
                alu_b = r_before;
            end
            ST_R_SCORE: begin
                alu_a = r_acc;
                alu_b = DW'(r_baseline);
            end
            ST_R_UPD: begin
                alu_a = score;
                alu_b = entry.min_delta;
            end
            ST_E_CAP: begin
                alu_a = DW'(r_batch);
                alu_b = DW'(entry.clean);
            end
            ST_E_STM: begin
                alu_a = DW'(r_cap);
                alu_b = DW'(r_storm_thr);
            end
            ST_E_LOW: begin
                alu_a = entry.min_delta;
                alu_b = r_lowest;
            end
            ST_S_HI: begin
                alu_a   = r_delta_avg;
                alu_b   = r_delta_spr;
                alu_sub = 1'b0;
            end
            ST_S_CMPHI: begin
                alu_a = r_lowest;
                alu_b = r_acc;
            end
            ST_S_LO: begin
                alu_a = r_delta_avg;
                alu_b = r_delta_spr;
            end
            ST_S_CMPLO: begin
                alu_a = r_acc;
                alu_b = r_lowest;
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    // store access and next state
    always_comb begin
        n_state = r_state;
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_data = entry;
        clr     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_operation == rcam_pkg::OP_EVALUATE) begin
                        rd_en   = 1'b1;
                        n_state = ST_E_CAP;
                    end else if (core_ok) begin
                        rd_en   = 1'b1;
                        rd_addr = core_ext[CORE_W-1:0];
                        n_state = ST_R_DIFF;
                    end
                end
            end
            ST_R_DIFF: begin
                if (!r_enabled) begin
                    wr_en       = 1'b1;
                    wr_data.off = 1'b1;
                    n_state     = ST_IDLE;
                end else begin
                    n_state = ST_R_SCORE;
                end
            end
            ST_R_SCORE: n_state = ST_R_UPD;
            ST_R_UPD: begin
                wr_en = 1'b1;
                if (score != '0) begin
                    if (entry.min_delta == '0 || alu_borrow) begin
                        wr_data.min_delta = score;
                    end
                end else if (entry.clean != '1) begin
                    wr_data.clean = entry.clean + CW'(1);
                end
                n_state = ST_IDLE;
            end
            ST_E_CAP: n_state = ST_E_STM;
            ST_E_STM: begin
                if (out_free) begin
                    n_state = ST_E_LOW;
                end
            end
            ST_E_LOW: begin
                if (idx_last) begin
                    n_state = ST_S_HI;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx + CORE_W'(1);
                    n_state = ST_E_CAP;
                end
            end
            ST_S_HI:    n_state = ST_S_CMPHI;
            ST_S_CMPHI: n_state = ST_S_LO;
            ST_S_LO:    n_state = ST_S_CMPLO;
            ST_S_CMPLO: begin
                if (out_free) begin
                    clr     = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_o_valid   <= 1'b0;
            r_baseline  <= rcam_pkg::BASELINE_RST;
            r_dead_zone <= rcam_pkg::DEAD_ZONE_RST;
            r_batch     <= rcam_pkg::BATCH_RST;
            r_storm_thr <= rcam_pkg::STORM_THR_RST;
            r_delta_avg <= rcam_pkg::DELTA_AVG_RST;
            r_delta_spr <= rcam_pkg::DELTA_SPR_RST;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_E_STM || r_state == ST_S_CMPLO) && out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rcam_pkg::CFG_BASELINE:  r_baseline  <= i_cfg_data[rcam_pkg::BASE_W-1:0];
                    rcam_pkg::CFG_DEAD_ZONE: r_dead_zone <= i_cfg_data[rcam_pkg::DZ_W-1:0];
                    rcam_pkg::CFG_BATCH:     r_batch     <= i_cfg_data[CW-1:0];
                    rcam_pkg::CFG_STORM_THR: r_storm_thr <= i_cfg_data[CW-1:0];
                    rcam_pkg::CFG_DELTA_AVG: r_delta_avg <= i_cfg_data;
                    rcam_pkg::CFG_DELTA_SPR: r_delta_spr <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // datapath and output payload
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_enabled <= i_counter_enabled;
                    r_core    <= core_ext[CORE_W-1:0];
                    r_before  <= i_count_before;
                    r_after   <= i_count_after;
                    r_idx     <= '0;
                    r_lowest  <= '0;
                    r_storm   <= 1'b0;
                end
            end
            ST_R_DIFF, ST_R_SCORE, ST_S_HI, ST_S_LO: begin
                r_acc <= alu_sum;
            end
            ST_E_CAP: begin
                r_cap <= alu_borrow ? '0 : alu_sum[CW-1:0];
            end
            ST_E_STM: begin
                if (out_free) begin
                    r_storm      <= r_storm | st_now;
                    r_o_kind     <= rcam_pkg::KIND_CORE;
                    r_o_core     <= rcam_pkg::CORE_EXT_W'(r_idx) >> 0 == 0 ? 4'd0
                                    : 4'(rcam_pkg::CORE_EXT_W'(r_idx));
                    r_o_clean    <= entry.clean;
                    r_o_least    <= entry.min_delta;
                    r_o_off      <= entry.off;
                    r_o_cap      <= r_cap;
                    r_o_storming <= st_now;
                    r_o_lowest   <= '0;
                    r_o_in_win   <= 1'b0;
                    r_o_any      <= 1'b0;
                    r_o_last     <= 1'b0;
                end
            end
            ST_E_LOW: begin
                if (entry.min_delta != '0 && (r_lowest == '0 || alu_borrow)) begin
                    r_lowest <= entry.min_delta;
                end
                r_idx <= r_idx + CORE_W'(1);
            end
            ST_S_CMPHI: begin
                r_lt_hi <= alu_borrow;
            end
            ST_S_CMPLO: begin
                if (out_free) begin
                    r_o_kind     <= rcam_pkg::KIND_SUMMARY;
                    r_o_core     <= '0;
                    r_o_clean    <= '0;
                    r_o_least    <= '0;
                    r_o_off      <= 1'b0;
                    r_o_cap      <= '0;
                    r_o_storming <= 1'b0;
                    r_o_lowest   <= r_lowest;
                    // lo < lowest < hi, and some delta was seen
                    r_o_in_win   <= (r_lowest != '0) && r_lt_hi && alu_borrow;
                    r_o_any      <= r_storm;
                    r_o_last     <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid       = r_o_valid;
    assign o_report_kind     = r_o_kind;
    assign o_report_core     = r_o_core;
    assign o_clean_samples   = r_o_clean;
    assign o_least_delta     = r_o_least;
    assign o_counter_was_off = r_o_off;
    assign o_captured_count  = r_o_cap;
    assign o_core_storming   = r_o_storming;
    assign o_lowest_delta    = r_o_lowest;
    assign o_delta_in_window = r_o_in_win;
    assign o_any_storming    = r_o_any;
    assign o_last            = r_o_last;

    // a new result only comes from a scan step or the summary step
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> ($past(r_state) == ST_E_STM || $past(r_state) == ST_S_CMPLO))
        else $error("result raised outside a report step");

    // the summary, once placed, returns the sequencer to idle
    a_sum_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_S_CMPLO && out_free) |=> (r_state == ST_IDLE))
        else $error("summary did not end the evaluation");

    // scan index never runs past the last core
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_E_CAP || r_state == ST_E_STM || r_state == ST_E_LOW)
        |-> (r_idx <= CORE_W'(NUM_CORES - 1)))
        else $error("scan index out of range");

    // per-core reports never carry the end marker
    a_core_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_kind == rcam_pkg::KIND_CORE) |-> !r_o_last)
        else $error("core report marked last");

endmodule
